// ----- rtl/core/pse_pkg.sv -----
// Shared types and constants for the postfix stack evaluator.
`timescale 1ns / 1ps

package pse_pkg;

	localparam int DATA_W      = 32;
	localparam int STACK_DEPTH = 128;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int STEP_W      = $clog2(DATA_W);

	typedef enum logic [1:0] {
		KIND_OPERAND  = 2'd0,
		KIND_OPERATOR = 2'd1,
		KIND_FINISH   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_FETCH,
		FSM_CALC,
		FSM_POST
	} fsm_t;

	typedef enum logic [1:0] {
		ALU_IDLE,
		ALU_RUN,
		ALU_FIX
	} alu_phase_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_ctl_t;

endpackage

// ----- rtl/core/pse_stack.sv -----
// Stack storage below the top entry: one write port, one registered read port.
`timescale 1ns / 1ps

module pse_stack
	import pse_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/pse_alu.sv -----
// Serial arithmetic unit: bit-serial add/subtract, shift-add multiply, restoring divide.
`timescale 1ns / 1ps

module pse_alu
	import pse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  alu_ctl_t          ctl,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output logic              done,
	output logic [DATA_W-1:0] result
);

	alu_phase_t        phase_q, phase_d;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	op_t               op_q;
	logic [DATA_W-1:0] x_q, y_q, acc_q, result_q;
	logic              carry_q, neg_q;
	logic [DATA_W-1:0] mag_a, mag_b;
	logic              yb, sum_bit, sum_carry;
	logic [DATA_W:0]   mul_sum, div_part, div_diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ALU_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == ALU_FIX);
			if (phase_q == ALU_RUN) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			ALU_IDLE: if (ctl.start) phase_d = ALU_RUN;
			ALU_RUN:  if (step_q == STEP_W'(DATA_W - 1)) phase_d = ALU_FIX;
			ALU_FIX:  phase_d = ALU_IDLE;
			default:  phase_d = ALU_IDLE;
		endcase
	end

	always_comb begin
		mag_a     = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
		mag_b     = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
		yb        = y_q[0] ^ (op_q == OP_SUB);
		sum_bit   = x_q[0] ^ yb ^ carry_q;
		sum_carry = (x_q[0] & yb) | (x_q[0] & carry_q) | (yb & carry_q);
		mul_sum   = {1'b0, acc_q} + {1'b0, (y_q[0] ? x_q : '0)};
		div_part  = {acc_q, y_q[DATA_W-1]};
		div_diff  = div_part - {1'b0, x_q};
	end

	// Datapath: operands shift through x/y; a sum gathers in acc, while product and quotient bits shift into y.
	always_ff @(posedge clk) begin
		if (ctl.start && phase_q == ALU_IDLE) begin
			op_q    <= ctl.op;
			x_q     <= (ctl.op == OP_DIV) ? mag_b : a;
			y_q     <= (ctl.op == OP_DIV) ? mag_a : b;
			acc_q   <= '0;
			carry_q <= (ctl.op == OP_SUB);
			neg_q   <= (ctl.op == OP_DIV) && (a[DATA_W-1] ^ b[DATA_W-1]);
		end else if (phase_q == ALU_RUN) begin
			case (op_q)
				OP_ADD, OP_SUB: begin
					x_q     <= {1'b0, x_q[DATA_W-1:1]};
					y_q     <= {1'b0, y_q[DATA_W-1:1]};
					acc_q   <= {sum_bit, acc_q[DATA_W-1:1]};
					carry_q <= sum_carry;
				end
				OP_MUL: begin
					acc_q <= mul_sum[DATA_W:1];
					y_q   <= {mul_sum[0], y_q[DATA_W-1:1]};
				end
				default: begin
					if (!div_diff[DATA_W]) begin
						acc_q <= div_diff[DATA_W-1:0];
						y_q   <= {y_q[DATA_W-2:0], 1'b1};
					end else begin
						acc_q <= div_part[DATA_W-1:0];
						y_q   <= {y_q[DATA_W-2:0], 1'b0};
					end
				end
			endcase
		end else if (phase_q == ALU_FIX) begin
			if (op_q == OP_ADD || op_q == OP_SUB) begin
				result_q <= acc_q;
			end else if (neg_q) begin
				result_q <= ~y_q + DATA_W'(1);
			end else begin
				result_q <= y_q;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/core/postfix_stack_evaluator_top.sv -----
// Top level of the postfix stack evaluator: token control, stack top and result register.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  tuser: kind; tdata: op, operand_value
//  m_*       out  m_tvalid/m_tready  tdata: status, top_value; tlast: is_final
//
//  An operand, finish or ignored token goes from IDLE to POST and back to IDLE; an
//  operator also passes FETCH and CALC, where the ALU runs its 32-step serial loop.
//  Failing operators (underflow, divide by zero) skip the ALU; s_tready waits for IDLE.
//  Reset clears the stack count, the error and the output valid; the stack memory
//  needs no clearing, as only written entries are ever read.
//  A new token is taken while a result still waits; a stalled result holds the
//  token's commit until the output register frees.

module postfix_stack_evaluator_top
	import pse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] op, [33:2] operand_value, [39:34] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] status, [33:2] top_value, [39:34] zero
	output logic        m_tlast    // is_final
);

	fsm_t              state_q, state_d;
	logic [1:0]        kind_q;
	op_t               op_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] top_q;
	logic [CNT_W-1:0]  cnt_q;
	status_t           err_q;
	logic              m_tvalid_q;
	status_t           out_status_q;
	logic [DATA_W-1:0] out_top_q;
	logic              out_final_q;

	logic              accept, need_calc, out_free, commit;
	op_t               op_in;
	logic [DATA_W-1:0] val_in;

	logic [DATA_W-1:0] nxt_top;
	logic [CNT_W-1:0]  nxt_cnt;
	status_t           nxt_err;
	status_t           out_status;
	logic [DATA_W-1:0] out_top;
	logic              out_final;
	logic              wr_en;

	alu_ctl_t          alu_ctl;
	logic              alu_done;
	logic [DATA_W-1:0] alu_result;
	logic [DATA_W-1:0] rd_data;

	assign op_in    = op_t'(s_tdata[1:0]);
	assign val_in   = s_tdata[33:2];
	assign s_tready = (state_q == FSM_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == FSM_POST) && out_free;

	// Only a well-formed operator on a clean stack goes through the ALU.
	assign need_calc = (s_tuser == KIND_OPERATOR) && (err_q == ST_OK)
		&& (cnt_q >= CNT_W'(2)) && !((op_in == OP_DIV) && (top_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		alu_ctl.start = 1'b0;
		alu_ctl.op    = op_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) state_d = need_calc ? FSM_FETCH : FSM_POST;
			end
			FSM_FETCH: begin
				// Second operand arrives from the stack memory this cycle.
				alu_ctl.start = 1'b1;
				state_d       = FSM_CALC;
			end
			FSM_CALC: begin
				if (alu_done) state_d = FSM_POST;
			end
			FSM_POST: begin
				if (out_free) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// Latch the token on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			op_q   <= op_in;
			val_q  <= val_in;
		end
	end

	// Work out the stack update and the reported result for the held token.
	always_comb begin
		nxt_top    = top_q;
		nxt_cnt    = cnt_q;
		nxt_err    = err_q;
		out_final  = 1'b0;
		wr_en      = 1'b0;
		out_status = err_q;
		out_top    = '0;
		unique case (kind_q)
			KIND_FINISH: begin
				if (err_q != ST_OK) begin
					out_status = err_q;
				end else if (cnt_q == '0) begin
					out_status = ST_UNDERFLOW;
				end else begin
					out_status = ST_OK;
					out_top    = top_q;
				end
				nxt_cnt   = '0;
				nxt_err   = ST_OK;
				out_final = 1'b1;
			end
			KIND_OPERAND: begin
				if (err_q == ST_OK) begin
					if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
						nxt_err = ST_OVERFLOW;
					end else begin
						wr_en   = (cnt_q != '0);
						nxt_top = val_q;
						nxt_cnt = cnt_q + CNT_W'(1);
					end
				end
			end
			KIND_OPERATOR: begin
				if (err_q == ST_OK) begin
					if (cnt_q < CNT_W'(2)) begin
						nxt_err = ST_UNDERFLOW;
					end else if ((op_q == OP_DIV) && (top_q == '0)) begin
						nxt_err = ST_DIVZERO;
					end else begin
						nxt_top = alu_result;
						nxt_cnt = cnt_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
		if (kind_q != KIND_FINISH) begin
			out_status = nxt_err;
			out_top    = (nxt_cnt != '0) ? nxt_top : '0;
		end
	end

	// Stack control state: count and sticky error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= ST_OK;
		end else if (commit) begin
			cnt_q <= nxt_cnt;
			err_q <= nxt_err;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			top_q <= nxt_top;
		end
	end

	// Output register: hold the transaction until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= out_status;
			out_top_q    <= out_top;
			out_final_q  <= out_final;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_top_q, out_status_q};
	assign m_tlast  = out_final_q;

	// Memory holds every entry below the top; push the old top, read the second entry.
	pse_stack u_stack (
		.clk     (clk),
		.wr_en   (commit && wr_en),
		.wr_addr (ADDR_W'(cnt_q - CNT_W'(1))),
		.wr_data (top_q),
		.rd_en   (accept && need_calc),
		.rd_addr (ADDR_W'(cnt_q - CNT_W'(2))),
		.rd_data (rd_data)
	);

	pse_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (rd_data),
		.b      (top_q),
		.done   (alu_done),
		.result (alu_result)
	);

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == FSM_CALC)
		else $error("ALU finished outside the calculate state");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		commit && kind_q == KIND_FINISH |=> cnt_q == '0 && err_q == ST_OK)
		else $error("finish did not empty the stack");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		commit && err_q != ST_OK && kind_q != KIND_FINISH |=> err_q == $past(err_q))
		else $error("pending error changed before finish");

	a_calc_has_operands: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_FETCH |-> cnt_q >= CNT_W'(2) && err_q == ST_OK)
		else $error("ALU started without two operands");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the postfix stack evaluator: stack predictor, random tokens, random stalls.
`timescale 1ns / 1ps

module testbench;
	import pse_pkg::*;

	localparam int TOTAL_ITEMS    = 1450;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 100;
	// the tuser code that no kind uses; the block reports its state and changes nothing
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] top;
		logic              is_final;
	} eval_result_t;

	// Tracks the evaluator's stack and sticky error, and holds the results still owed.
	class stack_tracker;
		logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
		int                depth = 0;
		status_t           err = ST_OK;
		eval_result_t      pending_results [$];
		int                fail_count = 0;

		// divide truncating toward zero; the most negative value over minus one wraps
		function logic [DATA_W-1:0] trunc_quotient(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			logic [DATA_W-1:0] ma;
			logic [DATA_W-1:0] mb;
			logic [DATA_W-1:0] q;
			ma = a[DATA_W-1] ? 32'd0 - a : a;
			mb = b[DATA_W-1] ? 32'd0 - b : b;
			q  = ma / mb;
			return (a[DATA_W-1] ^ b[DATA_W-1]) ? 32'd0 - q : q;
		endfunction

		function void take_token(logic [1:0] kind, logic [1:0] op, logic [DATA_W-1:0] value);
			eval_result_t      res;
			logic [DATA_W-1:0] lhs;
			logic [DATA_W-1:0] rhs;
			logic [DATA_W-1:0] acc;
			logic              calc_ok;
			res.is_final = 1'b0;
			acc = '0;
			if (kind == KIND_FINISH) begin
				res.is_final = 1'b1;
				if (err != ST_OK) begin
					res.status = err;
					res.top    = '0;
				end else if (depth == 0) begin
					res.status = ST_UNDERFLOW;
					res.top    = '0;
				end else begin
					res.status = ST_OK;
					res.top    = stack_mem[depth-1];
				end
				depth = 0;
				err   = ST_OK;
			end else begin
				if (err == ST_OK && kind == KIND_OPERAND) begin
					if (depth >= STACK_DEPTH) begin
						err = ST_OVERFLOW;
					end else begin
						stack_mem[depth] = value;
						depth++;
					end
				end else if (err == ST_OK && kind == KIND_OPERATOR) begin
					if (depth < 2) begin
						err = ST_UNDERFLOW;
					end else begin
						rhs     = stack_mem[depth-1];
						lhs     = stack_mem[depth-2];
						calc_ok = 1'b1;
						case (op_t'(op))
							OP_ADD: acc = lhs + rhs;
							OP_SUB: acc = lhs - rhs;
							OP_MUL: acc = lhs * rhs;
							default: begin
								if (rhs == '0) begin
									calc_ok = 1'b0;
									err     = ST_DIVZERO;
								end else begin
									acc = trunc_quotient(lhs, rhs);
								end
							end
						endcase
						if (calc_ok) begin
							stack_mem[depth-2] = acc;
							depth--;
						end
					end
				end
				res.status = err;
				res.top    = (depth == 0) ? '0 : stack_mem[depth-1];
			end
			pending_results.push_back(res);
		endfunction

		function void check_result(logic [39:0] data, logic tlast_seen);
			eval_result_t      want;
			logic [1:0]        got_status;
			logic [DATA_W-1:0] got_top;
			got_status = data[1:0];
			got_top    = data[33:2];
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d top %0d is_final %0b",
					$time, got_status, $signed(got_top), tlast_seen);
				fail_count++;
				return;
			end
			want = pending_results.pop_front();
			if (got_status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.status, got_status);
				fail_count++;
			end
			if (got_top !== want.top) begin
				$display("%0t: top_value mismatch: expected %0d, actual %0d",
					$time, $signed(want.top), $signed(got_top));
				fail_count++;
			end
			if (tlast_seen !== want.is_final) begin
				$display("%0t: is_final mismatch: expected %0b, actual %0b",
					$time, want.is_final, tlast_seen);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	stack_tracker tracker = new;
	int           items_sent = 0;
	int           burst_left = 0;
	int           quiet_cycles = 0;

	postfix_stack_evaluator_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Hold reset low at start-up, then release it for good.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Operand values: small numbers (zero divisors among them), the extremes, or anything.
	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			v = $urandom_range(0, 20);
			return v - 10;
		end else if (r < 42) begin
			case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				3: return 32'd1;
				default: return 32'd0;
			endcase
		end
		return $urandom;
	endfunction

	// Drive one token and wait for its transaction. Valid stays high straight into the
	// next token when no gap is due, so it is never lowered and raised in one step.
	task automatic send_token(input logic [1:0] kind, input logic [1:0] op,
			input logic [DATA_W-1:0] value);
		int gap;
		gap = (burst_left > 0) ? 0 : pick_gap();
		if (burst_left > 0)
			burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'b0, value, op};
		do @(posedge clk); while (!s_tready);
		tracker.take_token(kind, op, value);
		items_sent++;
	endtask

	// A well-formed expression with random content; sometimes it leaves extra entries
	// below the top at finish, and small divisors now and then trip a divide by zero.
	task automatic gen_expression();
		int operands;
		int keep;
		int pushed;
		int depth;
		operands = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 7);
		keep     = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1;
		pushed   = 0;
		depth    = 0;
		while (pushed < operands || depth > keep) begin
			if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
				send_token(KIND_OPERAND, 2'($urandom_range(0, 3)), pick_value());
				pushed++;
				depth++;
			end else begin
				send_token(KIND_OPERATOR, 2'($urandom_range(0, 3)), $urandom);
				depth--;
			end
		end
		send_token(KIND_FINISH, 2'($urandom_range(0, 3)), $urandom);
	endtask

	// Noise: any kind in any order, the unused kind included; usually closed by a finish,
	// otherwise the next expression starts on whatever is left.
	task automatic gen_noise();
		int len;
		len = $urandom_range(1, 8);
		repeat (len)
			send_token(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_value());
		if ($urandom_range(0, 9) < 7)
			send_token(KIND_FINISH, 2'($urandom_range(0, 3)), $urandom);
	endtask

	// Fill the stack to the brim, plus any extra pushes, which overflow it, then operate and finish.
	task automatic fill_stack(input int extra);
		repeat (STACK_DEPTH + extra)
			send_token(KIND_OPERAND, 2'($urandom_range(0, 3)), pick_value());
		send_token(KIND_OPERATOR, OP_ADD, $urandom);
		send_token(KIND_FINISH, 2'($urandom_range(0, 3)), $urandom);
	endtask

	// Result side: runs of ready broken by random stalls, sometimes a long clean stretch.
	initial begin
		int run_len;
		int stall_len;
		@(posedge arst_n);
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
			m_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall_len = pick_gap();
			if (stall_len > 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// Check every result transaction against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata, m_tlast);
	end

	// Watchdog: end the run if neither side moves a transaction for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int r;
		@(posedge arst_n);
		@(posedge clk);

		// finish on an empty stack reports underflow
		send_token(KIND_FINISH, OP_ADD, '0);
		// operator on an empty stack; later tokens are ignored while the error stands
		send_token(KIND_OPERATOR, OP_ADD, '0);
		send_token(KIND_OPERAND, OP_SUB, 32'd5);
		send_token(KIND_IGNORED, OP_DIV, '1);
		send_token(KIND_FINISH, OP_MUL, '0);
		// wrap on add, most negative over minus one, wrap on multiply
		send_token(KIND_OPERAND, OP_ADD, 32'h7FFF_FFFF);
		send_token(KIND_OPERAND, OP_ADD, 32'd1);
		send_token(KIND_OPERATOR, OP_ADD, '0);
		send_token(KIND_OPERAND, OP_ADD, 32'hFFFF_FFFF);
		send_token(KIND_OPERATOR, OP_DIV, '0);
		send_token(KIND_OPERAND, OP_ADD, 32'h7FFF_FFFF);
		send_token(KIND_OPERATOR, OP_MUL, '0);
		send_token(KIND_IGNORED, OP_ADD, '0);
		// subtract, truncating divide of mixed signs, finish with several entries
		send_token(KIND_OPERAND, OP_ADD, 32'd22);
		send_token(KIND_OPERAND, OP_ADD, 32'hFFFF_FFF9);
		send_token(KIND_OPERATOR, OP_DIV, '0);
		send_token(KIND_OPERAND, OP_ADD, 32'd9);
		send_token(KIND_OPERATOR, OP_SUB, '0);
		send_token(KIND_OPERAND, OP_ADD, 32'd3);
		send_token(KIND_FINISH, OP_ADD, '0);
		// divide by zero, then a push that must be ignored
		send_token(KIND_OPERAND, OP_ADD, 32'd10);
		send_token(KIND_OPERAND, OP_ADD, 32'd0);
		send_token(KIND_OPERATOR, OP_DIV, '0);
		send_token(KIND_OPERAND, OP_ADD, 32'd4);
		send_token(KIND_FINISH, OP_ADD, '0);

		// a completely full stack, then one that overflows
		fill_stack(0);
		fill_stack($urandom_range(1, 3));

		while (items_sent < TOTAL_ITEMS) begin
			r = $urandom_range(0, 199);
			if (r < 6)
				burst_left = $urandom_range(10, 60);
			if (r == 0)
				fill_stack($urandom_range(0, 2));
			else if (r < 30)
				gen_noise();
			else
				gen_expression();
		end
		s_tvalid <= 1'b0;

		// drain: wait for every owed result, then allow for stray output
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
